// ----- rtl/crp_pkg.sv -----
// shared types and constants for the catmull-rom path evaluator
`timescale 1ns / 1ps
`default_nettype none
package crp_pkg;

    localparam int MaxPoints = 256;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = IdxW + 1;

    // item operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [16:0]        progress;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               valid_res;
    } out_beat_t;

    // request to the cubic unit
    typedef struct packed {
        logic               start;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] p3;
        logic [16:0]        t;
    } cubic_req_t;

endpackage : crp_pkg
`default_nettype wire

// ----- rtl/crp_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module crp_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write one word when we is set, and always read the word at addr
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : crp_ram
`default_nettype wire

// ----- rtl/crp_cubic.sv -----
// horner evaluation of one catmull-rom axis on one shared 33x18 multiplier
`timescale 1ns / 1ps
`default_nettype none
module crp_cubic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire crp_pkg::cubic_req_t req,
    output logic                    done,
    output logic signed [31:0]      result
);

    // coefficients a b c d need 36 bits; the exact sum stays below 2^85, kept in 96 bits
    // each horner step multiplies the accumulator by t one 32-bit limb a cycle, then adds
    typedef enum logic [2:0] { S_IDLE, S_COEF, S_MUL, S_ADD, S_OUT } state_t;

    state_t             state_reg, state_next;
    logic [16:0]        t_reg, t_next;
    logic signed [35:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic signed [35:0] ca_next, cb_next, cc_next, cd_next;
    logic [95:0]        acc_reg, acc_next;
    logic signed [19:0] carry_reg, carry_next;
    logic [1:0]         limb_reg, limb_next;
    logic [1:0]         step_reg, step_next;
    logic signed [31:0] res_reg, res_next;
    logic               done_reg, done_next;
    logic signed [35:0] add_val;
    logic [5:0]         add_sh;
    logic signed [32:0] mop;
    logic signed [50:0] mprod;
    logic signed [51:0] msum;
    logic signed [95:0] addend;
    logic signed [46:0] q;

    // shared multiplier: one limb times t plus the carry from the limb below
    always_comb
    begin
        case (limb_reg)
            2'd0:    mop = {1'b0, acc_reg[31:0]};
            2'd1:    mop = {1'b0, acc_reg[63:32]};
            default: mop = {acc_reg[95], acc_reg[95:64]};
        endcase
        mprod = mop * $signed({1'b0, t_reg});
        msum  = 52'(mprod) + 52'(carry_reg);
        case (step_reg)
            2'd0:    begin add_val = cc_reg; add_sh = 6'd16; end
            2'd1:    begin add_val = cb_reg; add_sh = 6'd32; end
            default: begin add_val = ca_reg; add_sh = 6'd48; end
        endcase
        addend = 96'(add_val) <<< add_sh;
        q = acc_reg[95:49];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        t_next = t_reg;
        ca_next = ca_reg; cb_next = cb_reg; cc_next = cc_reg; cd_next = cd_reg;
        acc_next = acc_reg;
        carry_next = carry_reg;
        limb_next = limb_reg;
        step_next = step_reg;
        res_next = res_reg;
        done_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    t_next = req.t;
                    ca_next = 36'(req.p1) <<< 1;
                    cb_next = 36'(req.p2) - 36'(req.p0);
                    cc_next = (36'(req.p0) <<< 1) - 36'(req.p1) * 36'sd5
                            + (36'(req.p2) <<< 2) - 36'(req.p3);
                    cd_next = 36'(req.p1) * 36'sd3 - 36'(req.p0)
                            - 36'(req.p2) * 36'sd3 + 36'(req.p3);
                    state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                acc_next = 96'(cd_reg);
                carry_next = '0;
                limb_next = 2'd0;
                step_next = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                case (limb_reg)
                    2'd0:    acc_next[31:0]  = msum[31:0];
                    2'd1:    acc_next[63:32] = msum[31:0];
                    default: acc_next[95:64] = msum[31:0];
                endcase
                carry_next = 20'(msum >>> 32);
                if (limb_reg == 2'd2)
                    state_next = S_ADD;
                else
                    limb_next = limb_reg + 2'd1;
            end
            S_ADD:
            begin
                acc_next = acc_reg + addend;
                carry_next = '0;
                limb_next = 2'd0;
                if (step_reg == 2'd2)
                    state_next = S_OUT;
                else
                begin
                    step_next = step_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (q > 47'sh7fffffff)
                    res_next = 32'sh7fffffff;
                else if (q < -47'sh80000000)
                    res_next = 32'sh80000000;
                else
                    res_next = q[31:0];
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        ca_reg <= ca_next; cb_reg <= cb_next; cc_reg <= cc_next; cd_reg <= cd_next;
        acc_reg <= acc_next;
        carry_reg <= carry_next;
        limb_reg <= limb_next;
        step_reg <= step_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule : crp_cubic
`default_nettype wire

// ----- rtl/catmull_rom_path_evaluator.sv -----
// catmull-rom path evaluator: point table, index sequencer and output beat
// clear/append are handled in idle without leaving it; a query on fewer than four points gives its beat next cycle
// a full query scales the progress, picks four indices, reads four points, then runs the cubic on each axis
// the single cubic unit (3 limb multiplies and an add per horner step) sets the query time
// one item at a time: input waits while a query runs or its output beat is not yet taken
// reset clears the point count and control; the point table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_path_evaluator (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire crp_pkg::in_beat_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output crp_pkg::out_beat_t       out_data
);

    localparam int IdxW = crp_pkg::IdxW;
    localparam int CntW = crp_pkg::CntW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_IDX, S_RD, S_RDW, S_CAP, S_EVAL, S_WAIT, S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [CntW-1:0]       count_reg, count_next;
    logic [16:0]           prog_reg, prog_next;
    logic [CntW+16:0]      scaled_reg, scaled_next;
    logic [IdxW-1:0]       idx_reg [4];
    logic [IdxW-1:0]       idx_next [4];
    logic [16:0]           t_reg, t_next;
    logic [1:0]            rd_reg, rd_next;
    logic [1:0]            cap_reg, cap_next;
    logic [1:0]            axis_reg, axis_next;
    logic signed [31:0]    pts_reg [3][4];
    logic signed [31:0]    res_reg [3];
    logic                  outv_reg, outv_next;
    logic                  valid_res_reg, valid_res_next;
    logic                  zero_res;
    logic                  wr_en;
    logic [IdxW-1:0]       ram_addr;
    logic [31:0]           rd_x, rd_y, rd_z;
    crp_pkg::cubic_req_t   creq;
    logic                  cdone;
    logic signed [31:0]    cres;
    logic [CntW-1:0]       segs, seg;
    logic [CntW:0]         i2w, i3w;

    assign in_ready = (state_reg == S_IDLE) && !outv_reg;
    assign wr_en = in_valid && in_ready && (in_data.op == crp_pkg::OP_APPEND)
                   && (count_reg < CntW'(crp_pkg::MaxPoints));
    assign ram_addr = (state_reg == S_IDLE) ? count_reg[IdxW-1:0] : idx_reg[rd_reg];

    // point tables
    crp_ram #(.Width(32), .Depth(crp_pkg::MaxPoints)) u_x (
        .clk(clk), .we(wr_en), .addr(ram_addr), .wdata(in_data.point_x), .rdata(rd_x));
    crp_ram #(.Width(32), .Depth(crp_pkg::MaxPoints)) u_y (
        .clk(clk), .we(wr_en), .addr(ram_addr), .wdata(in_data.point_y), .rdata(rd_y));
    crp_ram #(.Width(32), .Depth(crp_pkg::MaxPoints)) u_z (
        .clk(clk), .we(wr_en), .addr(ram_addr), .wdata(in_data.point_z), .rdata(rd_z));

    // shared cubic unit
    always_comb
    begin
        creq.start = (state_reg == S_EVAL);
        creq.p0 = pts_reg[axis_reg][0];
        creq.p1 = pts_reg[axis_reg][1];
        creq.p2 = pts_reg[axis_reg][2];
        creq.p3 = pts_reg[axis_reg][3];
        creq.t  = t_reg;
    end

    crp_cubic u_cubic (.clk(clk), .rst_n(rst_n), .req(creq), .done(cdone), .result(cres));

    // segment selection
    always_comb
    begin
        segs = count_reg - CntW'(1);
        seg  = CntW'(scaled_reg >> 16);
        if (seg >= segs)
            seg = segs - CntW'(1);
        i2w = {1'b0, seg} + (CntW+1)'(1);
        i3w = {1'b0, seg} + (CntW+1)'(2);
        if (i3w >= {1'b0, count_reg})
            i3w = {1'b0, segs};
        if (i2w >= {1'b0, count_reg})
            i2w = {1'b0, segs};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        prog_next = prog_reg;
        scaled_next = scaled_reg;
        idx_next = idx_reg;
        t_next = t_reg;
        rd_next = rd_reg;
        cap_next = cap_reg;
        axis_next = axis_reg;
        outv_next = outv_reg;
        valid_res_next = valid_res_reg;
        zero_res = 1'b0;
        if (outv_reg && out_ready)
            outv_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_data.op)
                        crp_pkg::OP_CLEAR:  count_next = '0;
                        crp_pkg::OP_APPEND:
                            if (wr_en)
                                count_next = count_reg + CntW'(1);
                        crp_pkg::OP_QUERY:
                        begin
                            if (count_reg < CntW'(4))
                            begin
                                zero_res = 1'b1;
                                valid_res_next = 1'b0;
                                outv_next = 1'b1;
                            end
                            else
                            begin
                                prog_next = (in_data.progress > 17'd65536) ? 17'd65536
                                            : in_data.progress;
                                state_next = S_SCALE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCALE:
            begin
                scaled_next = (CntW+17)'(prog_reg) * (CntW+17)'(segs);
                state_next = S_IDX;
            end
            S_IDX:
            begin
                idx_next[0] = (seg != '0) ? IdxW'(seg - CntW'(1)) : IdxW'(seg);
                idx_next[1] = IdxW'(seg);
                idx_next[2] = IdxW'(i2w);
                idx_next[3] = IdxW'(i3w);
                t_next = 17'(scaled_reg - ((CntW+17)'(seg) << 16));
                rd_next = 2'd0;
                state_next = S_RD;
            end
            S_RD:
            begin
                // address rd_reg presented; data comes next cycle
                rd_next = rd_reg + 2'd1;
                cap_next = rd_reg;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (cap_reg == 2'd3)
                begin
                    axis_next = 2'd0;
                    state_next = S_EVAL;
                end
                else
                    state_next = S_RD;
            end
            S_EVAL:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (cdone)
                begin
                    if (axis_reg == 2'd2)
                        state_next = S_OUT;
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                        state_next = S_EVAL;
                    end
                end
            end
            S_OUT:
            begin
                valid_res_next = 1'b1;
                outv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            outv_reg  <= 1'b0;
            rd_reg    <= '0;
            cap_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            outv_reg  <= outv_next;
            rd_reg    <= rd_next;
            cap_reg   <= cap_next;
            axis_reg  <= axis_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        prog_reg <= prog_next;
        scaled_reg <= scaled_next;
        idx_reg <= idx_next;
        t_reg <= t_next;
        valid_res_reg <= valid_res_next;
        if (state_reg == S_RDW)
        begin
            pts_reg[0][cap_reg] <= rd_x;
            pts_reg[1][cap_reg] <= rd_y;
            pts_reg[2][cap_reg] <= rd_z;
        end
        if (zero_res)
        begin
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
        end
        else if (state_reg == S_WAIT && cdone)
            res_reg[axis_reg] <= cres;
    end

    assign out_valid          = outv_reg;
    assign out_data.pos_x     = res_reg[0];
    assign out_data.pos_y     = res_reg[1];
    assign out_data.pos_z     = res_reg[2];
    assign out_data.valid_res = valid_res_reg;

endmodule : catmull_rom_path_evaluator
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for the catmull-rom path evaluator: random beats checked against a path predictor
`timescale 1ns / 1ps
`default_nettype none

class path_scoreboard;
    logic signed [31:0] xs [crp_pkg::MaxPoints];
    logic signed [31:0] ys [crp_pkg::MaxPoints];
    logic signed [31:0] zs [crp_pkg::MaxPoints];
    int unsigned        point_count;
    crp_pkg::out_beat_t pending_pos [$];
    int unsigned        mismatches;

    function new();
        point_count = 0;
        mismatches  = 0;
    endfunction

    // one axis of the uniform cubic, exact, floored and saturated
    function logic signed [31:0] cubic_axis(logic signed [31:0] q0,
            logic signed [31:0] q1, logic signed [31:0] q2, logic signed [31:0] q3,
            logic [16:0] t);
        logic signed [127:0] a, b, c, d, tt, acc, shifted;
        a   = 2 * 128'(q1);
        b   = 128'(q2) - 128'(q0);
        c   = 2 * 128'(q0) - 5 * 128'(q1) + 4 * 128'(q2) - 128'(q3);
        d   = -128'(q0) + 3 * 128'(q1) - 3 * 128'(q2) + 128'(q3);
        tt  = 128'(t);
        acc = ((d * tt + (c <<< 16)) * tt + (b <<< 32)) * tt + (a <<< 48);
        shifted = acc >>> 49;
        if (shifted > 128'sd2147483647)
            return 32'sh7fffffff;
        if (shifted < -128'sd2147483648)
            return 32'sh80000000;
        return shifted[31:0];
    endfunction

    // note an accepted input beat and queue any position it causes
    function void note_input(crp_pkg::in_beat_t b);
        crp_pkg::out_beat_t r;
        int unsigned segs, seg, i0, i1, i2, i3;
        logic [47:0] scaled;
        logic [47:0] t;
        logic [16:0] prog;
        case (b.op)
            crp_pkg::OP_CLEAR: point_count = 0;
            crp_pkg::OP_APPEND:
            begin
                if (point_count < crp_pkg::MaxPoints)
                begin
                    xs[point_count] = b.point_x;
                    ys[point_count] = b.point_y;
                    zs[point_count] = b.point_z;
                    point_count++;
                end
            end
            crp_pkg::OP_QUERY:
            begin
                r = '0;
                if (point_count >= 4)
                begin
                    prog   = (b.progress > 17'd65536) ? 17'd65536 : b.progress;
                    segs   = point_count - 1;
                    scaled = 48'(prog) * 48'(segs);
                    seg    = 32'(scaled >> 16);
                    if (seg >= segs)
                        seg = segs - 1;
                    t = scaled - (48'(seg) << 16);
                    if (t > 48'd65536)
                        t = 48'd65536;
                    i0 = (seg > 0) ? seg - 1 : seg;
                    i1 = seg;
                    i2 = (seg + 1 >= point_count) ? point_count - 1 : seg + 1;
                    i3 = (seg + 2 >= point_count) ? point_count - 1 : seg + 2;
                    r.pos_x = cubic_axis(xs[i0], xs[i1], xs[i2], xs[i3], t[16:0]);
                    r.pos_y = cubic_axis(ys[i0], ys[i1], ys[i2], ys[i3], t[16:0]);
                    r.pos_z = cubic_axis(zs[i0], zs[i1], zs[i2], zs[i3], t[16:0]);
                    r.valid_res = 1'b1;
                end
                pending_pos = {pending_pos, r};
            end
            default: ;
        endcase
    endfunction

    // compare an output beat against the oldest queued position
    function void check_result(crp_pkg::out_beat_t got);
        crp_pkg::out_beat_t want;
        if (pending_pos.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output beat %h", got);
            return;
        end
        want = pending_pos.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.pos_z !== want.pos_z || got.valid_res !== want.valid_res)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("position mismatch: exp x=%h y=%h z=%h v=%b got x=%h y=%h z=%h v=%b",
                         want.pos_x, want.pos_y, want.pos_z, want.valid_res,
                         got.pos_x, got.pos_y, got.pos_z, got.valid_res);
        end
    endfunction
endclass

module tb_top;
    import crp_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;
    bit        feed_done;

    path_scoreboard sb;

    catmull_rom_path_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // random coordinate: extremes, small values or anything
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3, 4: return 32'($signed($urandom_range(0, 32'h0040_0000))) - 32'h0020_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [16:0] rand_progress();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // send one beat after a random gap (none for the unused op), hold until accepted
    task automatic send_beat(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic [16:0] prog);
        int gap;
        gap = (op == OP_UNUSED) ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: op, point_x: px, point_y: py, point_z: pz, progress: prog};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(in_data);
    endtask

    task automatic append_random(int n);
        repeat (n) send_beat(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), 17'd0);
    endtask

    // pause the feed until every queued position is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_pos.size() != 0) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int sent, n;
        sb        = new();
        feed_done = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: query on empty table, unused op, extremes, end of path
        send_beat(OP_QUERY, '0, '0, '0, 17'd32768);
        send_beat(OP_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 17'h1ffff);
        send_beat(OP_APPEND, 32'h7fffffff, 32'h80000000, 32'h0, 17'd0);
        send_beat(OP_APPEND, 32'h80000000, 32'h7fffffff, 32'hffffffff, 17'd0);
        send_beat(OP_APPEND, 32'h7fffffff, 32'h80000000, 32'h00010000, 17'd0);
        send_beat(OP_QUERY, '0, '0, '0, 17'd65536);
        send_beat(OP_APPEND, 32'h80000000, 32'h7fffffff, 32'hffff0000, 17'd0);
        send_beat(OP_QUERY, '0, '0, '0, 17'd0);
        send_beat(OP_QUERY, '0, '0, '0, 17'd21845);
        send_beat(OP_QUERY, '0, '0, '0, 17'd65536);
        send_beat(OP_QUERY, '0, '0, '0, 17'h1ffff);
        send_beat(OP_QUERY, 32'hffffffff, 32'hffffffff, 32'hffffffff, 17'd43690);
        send_beat(OP_CLEAR, '0, '0, '0, 17'd0);
        send_beat(OP_QUERY, '0, '0, '0, 17'd100);
        drain();
        sent = 14;

        // fill the table past full, then query the long path
        append_random(MaxPoints + 3);
        repeat (8) send_beat(OP_QUERY, '0, '0, '0, rand_progress());
        send_beat(OP_QUERY, '0, '0, '0, 17'd65536);
        drain();
        send_beat(OP_CLEAR, '0, '0, '0, 17'd0);
        sent += MaxPoints + 13;

        // random paths: mostly small tables, clears, queries and noise
        while (sent < 1950)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
            send_beat(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_progress());
            append_random(n);
            sent += n + 1;
            repeat ($urandom_range(2, 10))
            begin
                case ($urandom_range(0, 19))
                    0: send_beat(OP_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                                 rand_progress());
                    1, 2: send_beat(OP_APPEND, rand_coord(), rand_coord(), rand_coord(),
                                    rand_progress());
                    default: send_beat(OP_QUERY, rand_coord(), rand_coord(), rand_coord(),
                                       rand_progress());
                endcase
                sent++;
            end
        end
        in_valid  <= 1'b0;
        feed_done = 1'b1;
    end

    // output side: random stall before each beat, sample at the edge
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            sb.check_result(out_data);
        end
    end

    // end of run
    initial
    begin
        wait (feed_done === 1'b1);
        while (sb.pending_pos.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_pos.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
rtl/crp_pkg.sv
rtl/crp_ram.sv
rtl/crp_cubic.sv
rtl/catmull_rom_path_evaluator.sv
tb/sv/tb_top.sv
